>>> hdl/rpe_pkg.sv
package rpe_pkg;

    // Run byte layout
    localparam int LEN_BITS = 7;

    // Results emitted per byte at most; further in-frame pixels only advance
    localparam int CNT_BITS    = 7;
    localparam int MAX_RESULTS = 64;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_ORIGIN   = 2'd2;

    // Configuration reset values
    localparam int RST_FRAME_WIDTH  = 240;
    localparam int RST_FRAME_HEIGHT = 180;
    localparam int RST_ROW_ORIGIN   = 250;

    // Grey levels
    localparam logic [7:0] GREY_BLACK = 8'h00;
    localparam logic [7:0] GREY_WHITE = 8'hFF;

    // Decoded run command, front to back
    typedef struct packed {
        logic                white;
        logic [LEN_BITS-1:0] len;
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

>>> hdl/rpe_front.sv
module rpe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_run_byte,
    output logic          o_full,
    output logic          o_cmd_valid,
    output rpe_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    rpe_pkg::t_cmd r_mem [2];
    rpe_pkg::t_cmd w_dec;
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    logic          w_wr;
    logic          w_rd;

    // Split the byte into pixel value and run length
    assign w_dec.white = i_run_byte[7];
    assign w_dec.len   = i_run_byte[rpe_pkg::LEN_BITS-1:0];

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rptr];

    assign w_wr = i_push && !o_full;
    assign w_rd = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_wr && w_rd) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (w_rd) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= w_dec;
        end
    end

endmodule

>>> hdl/rpe_expand.sv
module rpe_expand #(
    parameter int COORD_BITS = 10,
    parameter int RES_W      = 2 * COORD_BITS + 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [COORD_BITS-1:0] i_frame_width,
    input  logic [COORD_BITS-1:0] i_frame_height,
    input  logic [COORD_BITS-1:0] i_row_origin,
    input  logic                  i_cmd_valid,
    input  rpe_pkg::t_cmd         i_cmd,
    output logic                  o_cmd_pop,
    input  logic                  i_out_full,
    output logic                  o_res_push,
    output logic [RES_W-1:0]      o_res_data,
    output logic                  o_busy
);

    rpe_pkg::t_state r_state, n_state;
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [rpe_pkg::LEN_BITS-1:0] r_left, n_left;
    logic [rpe_pkg::CNT_BITS-1:0] r_emitted, n_emitted;
    logic r_white, n_white;
    logic [COORD_BITS-1:0] r_pend_col, n_pend_col;
    logic [COORD_BITS:0]   r_pend_row, n_pend_row;
    logic                  r_pend_white, n_pend_white;

    logic [COORD_BITS:0]   w_col_inc;
    logic                  w_wrap;
    logic [COORD_BITS-1:0] w_col_step;
    logic [COORD_BITS-1:0] w_row_step;
    logic                  w_done_after;
    logic                  w_last_pix;
    logic                  w_emitting;
    logic                  w_hold_last;
    logic [COORD_BITS:0]   w_scr_row;
    logic                  w_step;
    logic                  w_want_push;

    assign w_col_inc    = {1'b0, r_col} + {{COORD_BITS{1'b0}}, 1'b1};
    assign w_wrap       = (w_col_inc >= {1'b0, i_frame_width});
    assign w_col_step   = w_wrap ? '0 : w_col_inc[COORD_BITS-1:0];
    assign w_row_step   = w_wrap ? (r_row + COORD_BITS'(1)) : r_row;
    assign w_done_after = (w_row_step >= i_frame_height);
    assign w_last_pix   = (r_left == rpe_pkg::LEN_BITS'(1)) || w_done_after;
    assign w_emitting   = (r_emitted != rpe_pkg::CNT_BITS'(rpe_pkg::MAX_RESULTS));
    assign w_hold_last  = (r_emitted == rpe_pkg::CNT_BITS'(rpe_pkg::MAX_RESULTS - 1))
                          && !w_last_pix;
    assign w_scr_row    = {1'b0, i_row_origin} - {1'b0, r_row};

    assign o_busy     = (r_state == rpe_pkg::ST_RUN);
    assign o_res_push = w_want_push && !i_out_full;

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_left       = r_left;
        n_emitted    = r_emitted;
        n_white      = r_white;
        n_pend_col   = r_pend_col;
        n_pend_row   = r_pend_row;
        n_pend_white = r_pend_white;
        o_cmd_pop    = 1'b0;
        w_want_push  = 1'b0;
        w_step       = 1'b0;
        o_res_data   = {r_col, w_scr_row,
                        r_white ? rpe_pkg::GREY_WHITE : rpe_pkg::GREY_BLACK,
                        w_last_pix, w_last_pix && w_done_after};
        case (r_state)
            rpe_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (r_row >= i_frame_height) begin
                        // frame already complete: drop the byte, restart
                        n_col = '0;
                        n_row = '0;
                    end else if (i_cmd.len != '0) begin
                        n_state   = rpe_pkg::ST_RUN;
                        n_left    = i_cmd.len;
                        n_emitted = '0;
                        n_white   = i_cmd.white;
                    end
                end
            end
            rpe_pkg::ST_RUN: begin
                if (w_emitting && !w_hold_last) begin
                    w_want_push = 1'b1;
                    w_step      = !i_out_full;
                end else if (w_emitting) begin
                    // last result slot: hold it until the run settles its flags
                    n_pend_col   = r_col;
                    n_pend_row   = w_scr_row;
                    n_pend_white = r_white;
                    w_step       = 1'b1;
                end else begin
                    o_res_data = {r_pend_col, r_pend_row,
                                  r_pend_white ? rpe_pkg::GREY_WHITE : rpe_pkg::GREY_BLACK,
                                  1'b1, w_done_after};
                    if (w_last_pix) begin
                        w_want_push = 1'b1;
                        w_step      = !i_out_full;
                    end else begin
                        w_step = 1'b1;
                    end
                end
                if (w_step) begin
                    n_col  = w_col_step;
                    n_row  = w_row_step;
                    n_left = r_left - rpe_pkg::LEN_BITS'(1);
                    if (w_emitting) begin
                        n_emitted = r_emitted + rpe_pkg::CNT_BITS'(1);
                    end
                    if (w_last_pix) begin
                        n_state = rpe_pkg::ST_IDLE;
                        if (w_done_after) begin
                            n_col = '0;
                            n_row = '0;
                        end
                    end
                end
            end
            default: begin
                n_state = rpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpe_pkg::ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left       <= n_left;
        r_emitted    <= n_emitted;
        r_white      <= n_white;
        r_pend_col   <= n_pend_col;
        r_pend_row   <= n_pend_row;
        r_pend_white <= n_pend_white;
    end

endmodule

>>> hdl/rpe_out_queue.sv
module rpe_out_queue #(
    parameter int WIDTH = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rptr];

    assign w_wr = i_push && !o_full;
    assign w_rd = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_wr && w_rd) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= ~r_wptr;
            end
            if (w_rd) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> hdl/rle_pixel_run_expander.sv
// Channel   | Direction | Handshake        | Payload
// ----------+-----------+------------------+-------------------------------------------
// run input | in        | push / full      | i_run_byte
// pixels    | out       | empty / pop      | o_pixel_column, o_screen_row, o_pixel_value,
//           |           |                  | o_run_last, o_frame_last
// config    | in        | i_cfg_we         | i_cfg_idx, i_cfg_wdata
//
// For a byte with run length N the expander pops the command, then walks N pixels, one
// per cycle unless the result queue is full (fewer when the frame ends first). A zero length
// byte, or one that finds the row already at or past the frame height, is only popped.
// Reset is synchronous, active low: clear queues and counters, load 240 x 180, origin 250.
// Either side may stall: two-entry queues before and after the expander absorb the
// transactions, and the expander holds a pixel while the result queue is full.
module rle_pixel_run_expander #(
    parameter int COORD_BITS = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // run input
    input  logic                                  push,
    output logic                                  full,
    input  logic [7:0]                            i_run_byte,
    // pixel results
    output logic                                  empty,
    input  logic                                  pop,
    output logic [COORD_BITS-1:0]                 o_pixel_column,
    output logic signed [COORD_BITS:0]            o_screen_row,
    output logic [7:0]                            o_pixel_value,
    output logic                                  o_run_last,
    output logic                                  o_frame_last,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [rpe_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [COORD_BITS-1:0]                 i_cfg_wdata
);

    // column, screen row, grey level, run_last, frame_last
    localparam int RES_W = COORD_BITS + (COORD_BITS + 1) + 8 + 2;

    logic [COORD_BITS-1:0] r_frame_width;
    logic [COORD_BITS-1:0] r_frame_height;
    logic [COORD_BITS-1:0] r_row_origin;

    logic          w_cmd_valid;
    rpe_pkg::t_cmd w_cmd;
    logic          w_cmd_pop;
    logic          w_out_full;
    logic          w_res_push;
    logic [RES_W-1:0] w_res_data;
    logic [RES_W-1:0] w_out_data;
    logic          w_busy;

    // Configuration registers; writes to an unused index are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= COORD_BITS'(rpe_pkg::RST_FRAME_WIDTH);
            r_frame_height <= COORD_BITS'(rpe_pkg::RST_FRAME_HEIGHT);
            r_row_origin   <= COORD_BITS'(rpe_pkg::RST_ROW_ORIGIN);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpe_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata;
                rpe_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata;
                rpe_pkg::REG_ROW_ORIGIN:   r_row_origin   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Front: accept and decode run bytes into a short command queue
    rpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_run_byte  (i_run_byte),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Back: walk the frame counters one pixel per cycle unless the result queue is full
    rpe_expand #(
        .COORD_BITS (COORD_BITS),
        .RES_W      (RES_W)
    ) u_expand (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_row_origin   (r_row_origin),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_pop      (w_cmd_pop),
        .i_out_full     (w_out_full),
        .o_res_push     (w_res_push),
        .o_res_data     (w_res_data),
        .o_busy         (w_busy)
    );

    // Result queue decouples the consumer from the expander
    rpe_out_queue #(
        .WIDTH (RES_W)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_data),
        .o_full  (w_out_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (w_out_data)
    );

    // Unpack the oldest result
    assign o_pixel_column = w_out_data[RES_W-1 -: COORD_BITS];
    assign o_screen_row   = w_out_data[RES_W-COORD_BITS-1 -: COORD_BITS+1];
    assign o_pixel_value  = w_out_data[9:2];
    assign o_run_last     = w_out_data[1];
    assign o_frame_last   = w_out_data[0];

`ifndef NO_ASSERTIONS
    // Never push a pixel into a full result queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_out_full)
        else $error("result pushed while result queue full");

    // Pixels come only from a run in progress
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> w_busy)
        else $error("result pushed while expander idle");

    // A new command is taken only once the previous run is finished
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_busy)
        else $error("command popped during a run");
`endif

endmodule
